// ===== src/bmsp_pkg.sv =====
package bmsp_pkg;

	// Width of the saturating record counter.
	localparam int RECORD_COUNT_BITS = 32;

	// Result queue geometry.
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Parser phases.
	typedef enum logic [2:0] {
		PH_HDR,
		PH_LEN,
		PH_STR,
		PH_NUM,
		PH_ERR
	} phase_t;

	// Event codes on the result channel.
	localparam logic [2:0] EV_STR_LEN  = 3'd0;
	localparam logic [2:0] EV_STR_BYTE = 3'd1;
	localparam logic [2:0] EV_NUM      = 3'd2;
	localparam logic [2:0] EV_REC      = 3'd3;
	localparam logic [2:0] EV_STATUS   = 3'd4;

	// Field identifiers.
	localparam logic [4:0] FLD_DOMAIN    = 5'd0;
	localparam logic [4:0] FLD_PATH      = 5'd1;
	localparam logic [4:0] FLD_TARGET    = 5'd2;
	localparam logic [4:0] FLD_HASH      = 5'd3;
	localparam logic [4:0] FLD_UNKNOWN   = 5'd4;
	localparam logic [4:0] FLD_MODE      = 5'd5;
	localparam logic [4:0] FLD_INODE     = 5'd6;
	localparam logic [4:0] FLD_SIZE      = 5'd12;
	localparam logic [4:0] FLD_FLAG      = 5'd13;
	localparam logic [4:0] FLD_PROPCOUNT = 5'd14;
	localparam logic [4:0] FLD_PROPNAME  = 5'd15;
	localparam logic [4:0] FLD_PROPVALUE = 5'd16;
	localparam logic [4:0] FLD_VERSION   = 5'd17;
	localparam logic [4:0] FLD_SKIP      = 5'd18;

	// Stream status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_HDR   = 2'd1;
	localparam logic [1:0] ST_VER   = 2'd2;
	localparam logic [1:0] ST_NOREC = 2'd3;

	// Header layout and markers.
	localparam logic [2:0]  HDR_VER_POS  = 3'd4;
	localparam logic [2:0]  HDR_LAST_POS = 3'd5;
	localparam logic [7:0]  VERSION_A    = 8'h01;
	localparam logic [7:0]  VERSION_B    = 8'h05;
	localparam logic [7:0]  HDR_PAD      = 8'h00;
	localparam logic [15:0] ABSENT_LEN   = 16'hFFFF;

	// One result transaction.
	typedef struct packed {
		logic [2:0]  event_res;
		logic [4:0]  field;
		logic [63:0] value;
		logic        absent;
		logic [1:0]  status;
		logic        tail_dropped;
		logic [31:0] record_count;
		logic        last;
	} result_t;

	// Up to two results written into the queue in one cycle.
	typedef struct packed {
		logic    w0;
		logic    w1;
		result_t r0;
		result_t r1;
	} res_push_t;

	// Phase and byte count with which a field begins.
	typedef struct packed {
		phase_t      phase;
		logic [15:0] count;
	} fstart_t;

	// Expected text of the first four header bytes.
	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] b;
		begin
			case (pos)
				2'd0: b = 8'h6D;
				2'd1: b = 8'h62;
				2'd2: b = 8'h64;
				2'd3: b = 8'h62;
				default: b = 8'h62;
			endcase
			return b;
		end
	endfunction

	// Strings open with a two-byte length; numbers have a fixed size.
	function automatic fstart_t field_start(input logic [4:0] id);
		fstart_t fs;
		begin
			if (id inside {[FLD_DOMAIN:FLD_UNKNOWN], FLD_PROPNAME, FLD_PROPVALUE}) begin
				fs.phase = PH_LEN;
				fs.count = 16'd2;
			end else begin
				fs.phase = PH_NUM;
				if (id == FLD_MODE) fs.count = 16'd2;
				else if (id == FLD_SIZE) fs.count = 16'd8;
				else if (id == FLD_FLAG || id == FLD_PROPCOUNT) fs.count = 16'd1;
				else fs.count = 16'd4;
			end
			return fs;
		end
	endfunction

endpackage

// ===== src/bmsp_in_if.sv =====
interface bmsp_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

// ===== src/bmsp_out_if.sv =====
interface bmsp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [4:0]  field;
	logic [63:0] value;
	logic        absent;
	logic [1:0]  status;
	logic        tail_dropped;
	logic [31:0] record_count;
	logic        last;

	modport source (output valid, output event_res, output field, output value,
		output absent, output status, output tail_dropped, output record_count,
		output last, input ready);
	modport sink (input valid, input event_res, input field, input value,
		input absent, input status, input tail_dropped, input record_count,
		input last, output ready);
endinterface

// ===== src/bmsp_core.sv =====
module bmsp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	bmsp_in_if.sink               req_ch,
	input  logic                  space_ok,
	output bmsp_pkg::res_push_t   push
);
	import bmsp_pkg::*;

	logic                         valid_s1;
	logic                         req_type_s1;
	logic [7:0]                   data_byte_s1;
	logic                         s1_fire;

	phase_t                       phase_q, phase_n;
	logic [2:0]                   hdr_pos_q, hdr_pos_n;
	logic [4:0]                   fld_q, fld_n;
	logic [15:0]                  rem_q, rem_n;
	logic [63:0]                  acc_q, acc_n;
	logic [7:0]                   props_q, props_n;
	logic                         inrec_q, inrec_n;
	logic [1:0]                   err_q, err_n;
	logic [RECORD_COUNT_BITS-1:0] cnt_q, cnt_n;

	logic                         do_adv;
	logic                         do_fin;
	logic                         do_start;
	logic [4:0]                   start_id;
	logic [15:0]                  len;
	logic                         len_absent;
	logic [7:0]                   props_dec;
	fstart_t                      fs;
	result_t                      r_main;
	result_t                      r_rec;

	// The input register moves on whenever the queue has room for two results.
	assign s1_fire      = valid_s1 && space_ok;
	assign req_ch.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.ready && req_ch.valid) begin
			req_type_s1  <= req_ch.req_type;
			data_byte_s1 <= req_ch.data_byte;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			hdr_pos_q <= '0;
			fld_q     <= '0;
			rem_q     <= '0;
			acc_q     <= '0;
			props_q   <= '0;
			inrec_q   <= 1'b0;
			err_q     <= ST_OK;
			cnt_q     <= '0;
		end else begin
			phase_q   <= phase_n;
			hdr_pos_q <= hdr_pos_n;
			fld_q     <= fld_n;
			rem_q     <= rem_n;
			acc_q     <= acc_n;
			props_q   <= props_n;
			inrec_q   <= inrec_n;
			err_q     <= err_n;
			cnt_q     <= cnt_n;
		end
	end

	assign len        = {acc_q[7:0], data_byte_s1};
	assign len_absent = (fld_q >= FLD_TARGET) && (fld_q <= FLD_UNKNOWN) && (len == ABSENT_LEN);
	assign fs         = field_start(start_id);

	// Per-byte parse: at most one field result and one record-complete result.
	always_comb begin
		phase_n   = phase_q;
		hdr_pos_n = hdr_pos_q;
		fld_n     = fld_q;
		rem_n     = rem_q;
		acc_n     = acc_q;
		props_n   = props_q;
		inrec_n   = inrec_q;
		err_n     = err_q;
		cnt_n     = cnt_q;
		do_adv    = 1'b0;
		do_fin    = 1'b0;
		do_start  = 1'b0;
		start_id  = FLD_DOMAIN;
		props_dec = props_q - 8'd1;
		r_main    = '0;
		r_main.record_count = 32'(cnt_q);
		r_rec     = '0;
		push      = '0;

		if (s1_fire) begin
			if (req_type_s1) begin
				// End of stream: report and return to the reset state.
				push.w0 = 1'b1;
				r_main.event_res = EV_STATUS;
				r_main.tail_dropped = (phase_q == PH_LEN || phase_q == PH_STR ||
					phase_q == PH_NUM) ? inrec_q : 1'b0;
				if (err_q != ST_OK) r_main.status = err_q;
				else if (phase_q == PH_HDR) r_main.status = ST_HDR;
				else if (cnt_q == '0) r_main.status = ST_NOREC;
				else r_main.status = ST_OK;
				phase_n   = PH_HDR;
				hdr_pos_n = '0;
				fld_n     = '0;
				rem_n     = '0;
				acc_n     = '0;
				props_n   = '0;
				inrec_n   = 1'b0;
				err_n     = ST_OK;
				cnt_n     = '0;
			end else begin
				case (phase_q)
					PH_HDR: begin
						if (hdr_pos_q < HDR_VER_POS) begin
							if (data_byte_s1 != magic_byte(hdr_pos_q[1:0])) err_n = ST_HDR;
						end else if (hdr_pos_q == HDR_VER_POS) begin
							acc_n = 64'(data_byte_s1);
							if (data_byte_s1 != VERSION_A && data_byte_s1 != VERSION_B &&
								err_q == ST_OK) err_n = ST_VER;
						end else begin
							if (data_byte_s1 != HDR_PAD) err_n = ST_HDR;
						end
						hdr_pos_n = hdr_pos_q + 3'd1;
						if (hdr_pos_q >= HDR_LAST_POS) begin
							if (err_n != ST_OK) begin
								phase_n = PH_ERR;
							end else begin
								push.w0 = 1'b1;
								r_main.event_res = EV_NUM;
								r_main.field = FLD_VERSION;
								r_main.value = acc_q;
								do_start = 1'b1;
								start_id = FLD_DOMAIN;
							end
						end
					end
					PH_LEN: begin
						inrec_n = 1'b1;
						acc_n = 64'(len);
						rem_n = rem_q - 16'd1;
						if (rem_q == 16'd1) begin
							push.w0 = 1'b1;
							r_main.event_res = EV_STR_LEN;
							r_main.field = fld_q;
							r_main.value = len_absent ? 64'd0 : 64'(len);
							r_main.absent = len_absent;
							if (len == 16'd0 || len_absent) begin
								do_adv = 1'b1;
							end else begin
								phase_n = PH_STR;
								rem_n = len;
							end
						end
					end
					PH_STR: begin
						inrec_n = 1'b1;
						push.w0 = 1'b1;
						r_main.event_res = EV_STR_BYTE;
						r_main.field = fld_q;
						r_main.value = 64'(data_byte_s1);
						rem_n = rem_q - 16'd1;
						if (rem_q == 16'd1) do_adv = 1'b1;
					end
					PH_NUM: begin
						inrec_n = 1'b1;
						acc_n = {acc_q[55:0], data_byte_s1};
						rem_n = rem_q - 16'd1;
						if (rem_q == 16'd1) begin
							if (fld_q != FLD_SKIP) begin
								push.w0 = 1'b1;
								r_main.event_res = EV_NUM;
								r_main.field = fld_q;
								r_main.value = acc_n;
							end
							if (fld_q == FLD_PROPCOUNT) props_n = data_byte_s1;
							do_adv = 1'b1;
						end
					end
					default: begin
						// Header error: bytes are dropped until end of stream.
					end
				endcase

				// Step to the next field of the record.
				if (do_adv) begin
					do_start = 1'b1;
					case (fld_q)
						FLD_UNKNOWN: start_id = FLD_MODE;
						FLD_MODE:    start_id = FLD_SKIP;
						FLD_SKIP:    start_id = FLD_INODE;
						FLD_PROPCOUNT: begin
							if (props_n == 8'd0) do_fin = 1'b1;
							else start_id = FLD_PROPNAME;
						end
						FLD_PROPNAME: start_id = FLD_PROPVALUE;
						FLD_PROPVALUE: begin
							props_n = props_dec;
							if (props_dec == 8'd0) do_fin = 1'b1;
							else start_id = FLD_PROPNAME;
						end
						default: begin
							start_id = (fld_q + 5'd1 <= FLD_PROPCOUNT) ? fld_q + 5'd1 : FLD_DOMAIN;
						end
					endcase
				end

				// Record complete: count it and restart at the domain string.
				if (do_fin) begin
					if (cnt_q != '1) cnt_n = cnt_q + 1'b1;
					inrec_n = 1'b0;
					props_n = '0;
					start_id = FLD_DOMAIN;
					r_rec.event_res = EV_REC;
					r_rec.record_count = 32'(cnt_n);
				end

				if (do_start) begin
					fld_n   = start_id;
					acc_n   = '0;
					phase_n = fs.phase;
					rem_n   = fs.count;
				end
			end

			// Place the record-complete result behind any field result.
			if (do_fin) begin
				if (push.w0) begin
					push.w1 = 1'b1;
					r_rec.last = 1'b1;
				end else begin
					push.w0 = 1'b1;
					r_rec.last = 1'b1;
				end
			end else begin
				r_main.last = 1'b1;
			end
		end

		push.r0 = (do_fin && !(push.w1)) ? r_rec : r_main;
		push.r1 = r_rec;
	end

	// A second result in one cycle is always the record-complete event.
	assert property (@(posedge clk) disable iff (!arst_n)
		push.w1 |-> (push.w0 && push.r1.event_res == EV_REC && push.r1.last))
		else $error("second result is not a closing record-complete event");

	// Results are produced only from a byte taken out of the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		push.w0 |-> s1_fire)
		else $error("result produced without a parsed transaction");

	// End of stream rearms the parser and clears the count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && req_type_s1) |=> (phase_q == PH_HDR && cnt_q == '0 && err_q == ST_OK))
		else $error("parser not rearmed after end of stream");

endmodule

// ===== src/bmsp_res_fifo.sv =====
module bmsp_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  bmsp_pkg::res_push_t push,
	output logic                space_ok,
	bmsp_out_if.source          res_ch
);
	import bmsp_pkg::*;

	result_t              mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_q;
	logic [RES_PTR_W-1:0] rd_q;
	logic [RES_CNT_W-1:0] count_q;
	logic                 pop;
	result_t              head;

	assign space_ok = (count_q <= RES_CNT_W'(RES_DEPTH - 2));
	assign pop      = res_ch.valid && res_ch.ready;
	assign head     = mem[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_W'(push.w0) + RES_PTR_W'(push.w1);
			rd_q    <= rd_q + RES_PTR_W'(pop);
			count_q <= count_q + RES_CNT_W'(push.w0) + RES_CNT_W'(push.w1) - RES_CNT_W'(pop);
		end
	end

	// Result storage; the second result goes one slot behind the first.
	always_ff @(posedge clk) begin
		if (push.w0) mem[wr_q] <= push.r0;
		if (push.w1) mem[wr_q + RES_PTR_W'(1)] <= push.r1;
	end

	assign res_ch.valid        = (count_q != '0);
	assign res_ch.event_res    = head.event_res;
	assign res_ch.field        = head.field;
	assign res_ch.value        = head.value;
	assign res_ch.absent       = head.absent;
	assign res_ch.status       = head.status;
	assign res_ch.tail_dropped = head.tail_dropped;
	assign res_ch.record_count = head.record_count;
	assign res_ch.last         = head.last;

	// The queue never overfills.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue overflow");

	// Writes arrive only when two slots are free.
	assert property (@(posedge clk) disable iff (!arst_n)
		push.w0 |-> space_ok)
		else $error("result written into a queue without room");

endmodule

// ===== src/backup_manifest_stream_parser_top.sv =====
// Byte-serial parser for a backup manifest stream.
// The request channel carries one transaction per byte: req_type low with the
// next file byte in data_byte, or req_type high to mark the end of the stream.
// The result channel carries tagged events: string lengths,
// string bytes, numeric fields, record-complete events and the stream status.
// A byte yields zero, one or two events; last marks the final one of each byte.
// A byte taken is held in the input register, parsed from there, and its events
// are written into the result queue, from which the receiver takes them.
// Throughput: one byte per cycle while the queue keeps room for two events; a
// byte that closes a record produces two events. The rate is set by the single
// result port behind a four-entry result queue.
// Reset empties the input register and the queue and puts the parser back in
// its header phase with a zero record count; an end-of-stream transaction does
// the same to the parser after its status event.
// When the receiver stalls the queue fills, and request ready falls once
// fewer than two free entries remain; nothing is lost or reordered.
module backup_manifest_stream_parser_top (
	input logic        clk,
	input logic        arst_n,
	bmsp_in_if.sink    req_ch,
	bmsp_out_if.source res_ch
);
	import bmsp_pkg::*;

	res_push_t push;
	logic      space_ok;

	// Parser with its input register and state.
	bmsp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_ch   (req_ch),
		.space_ok (space_ok),
		.push     (push)
	);

	// Result queue towards the receiver.
	bmsp_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.res_ch   (res_ch)
	);

endmodule
